@@ rtl/core/tas_pkg.sv @@
// ---------------------------------------------------------------------------
// tas_pkg: shared constants for the tilt angle sector unit
// Field widths, approximation constants and angle limits used by the core.
// ---------------------------------------------------------------------------
package tas_pkg;

  // defaults for the top-level parameters
  localparam int INPUT_BITS_DEF = 20;
  localparam int SECTORS_DEF    = 64;

  // stream field layout
  localparam int FIELD_BITS = 20;
  localparam int IN_DATA_W  = 40;
  localparam int ANGLE_W    = 12;
  localparam int SECTOR_W   = 6;
  localparam int OUT_DATA_W = 24;

  // sign-extended sample width, wide enough for any INPUT_BITS up to 24
  localparam int SAT_W = 25;

  // rational approximation 10314*a*b / (18*a^2 + 5*b^2 + 1), quotient <= 448
  localparam int ATAN_NUM      = 10314;
  localparam int ATAN_NUM_BITS = 14;
  localparam int DEN_EXTRA     = 5;
  localparam int QUOT_BITS     = 9;

  // angle arithmetic in tenths of a degree
  localparam int ANG_CALC_W    = 14;
  localparam int ANGLE_QUARTER = 900;
  localparam int ANGLE_HALF    = 1800;
  localparam int ANGLE_FULL    = 3600;

  // reciprocal of the full turn for the sector division
  localparam int    RECIP_SHIFT = 32;
  localparam longint RECIP_FULL = ((longint'(1) <<< RECIP_SHIFT) + ANGLE_FULL - 1) / ANGLE_FULL;
  localparam int    SEC_PROD_W  = 48;

  // sideband carried alongside the arithmetic
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;
  } quad_t;

endpackage

@@ rtl/core/tilt_angle_sector_unit.sv @@
// Throughput: one sample per cycle unless stalled; the 9-stage quotient pipeline
//   (one quotient bit per stage) sets the depth; every stage holds one sample.
// Stalls: each stage advances when it is empty or the stage after it advances.
// Reset: synchronous, clears every stage valid bit; data registers are not reset.
// ---------------------------------------------------------------------------
// tilt_angle_sector_unit: accelerometer tilt direction
// Converts a signed x/y sample into an angle in tenths of a degree (0..3599)
// and a sector index, through a pipelined rational atan2 approximation.
// ---------------------------------------------------------------------------
module tilt_angle_sector_unit #(
  parameter int INPUT_BITS = tas_pkg::INPUT_BITS_DEF,
  parameter int SECTORS    = tas_pkg::SECTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata fields from bit 0: accel_x[19:0], accel_y[39:20]
  input  logic [tas_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata fields from bit 0: angle_tenths[11:0], sector_index[17:12], zero pad
  output logic [tas_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import tas_pkg::*;

  localparam int MAG_W   = INPUT_BITS;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int NUM_W   = PROD_W + ATAN_NUM_BITS;
  localparam int DEN_W   = PROD_W + DEN_EXTRA;
  localparam int ST_DIV0 = 3;
  localparam int ST_ANG  = ST_DIV0 + QUOT_BITS;
  localparam int ST_SEC  = ST_ANG + 1;
  localparam int N_ST    = ST_SEC + 1;

  localparam logic signed [SAT_W-1:0] SAT_MAX =
    SAT_W'((longint'(1) <<< (INPUT_BITS - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_MIN =
    SAT_W'(-(longint'(1) <<< (INPUT_BITS - 1)));
  localparam longint SEC_MULT = longint'(SECTORS) * RECIP_FULL;

  // sign-extend a field and clamp it to the INPUT_BITS range
  function automatic logic signed [SAT_W-1:0] saturate(input logic [FIELD_BITS-1:0] raw);
    logic signed [SAT_W-1:0] v;
    v = {{(SAT_W-FIELD_BITS){raw[FIELD_BITS-1]}}, raw};
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-1:0] a;
    a = v[SAT_W-1] ? SAT_W'(-v) : SAT_W'(v);
    return a[MAG_W-1:0];
  endfunction

  // stage valid bits and advance enables
  logic [N_ST-1:0] vld;
  logic [N_ST-1:0] adv;

  // stage 0: saturated magnitudes
  logic [MAG_W-1:0] big, lesser;
  // stage 1: products
  logic [PROD_W-1:0] p_ab, p_aa, p_bb;
  // stages 2 .. ST_ANG-1: remainder, divisor and quotient
  logic [NUM_W-1:0]     rem [0:QUOT_BITS];
  logic [DEN_W-1:0]     den [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] quo [1:QUOT_BITS];
  quad_t                quad [0:ST_ANG-1];
  // angle and output stages
  logic [ANGLE_W-1:0]  ang;
  logic [ANGLE_W-1:0]  out_angle;
  logic [SECTOR_W-1:0] out_sector;

  // stage 0 combinational inputs
  logic signed [SAT_W-1:0] xs, ys;
  logic [MAG_W-1:0]        mx, my;
  // angle stage and sector stage combinational values
  logic signed [ANG_CALC_W-1:0] ang_next;
  logic [SEC_PROD_W-1:0]        sec_prod;

  // chain the stall backwards from the output
  always_comb begin
    adv[N_ST-1] = !vld[N_ST-1] || m_axis_tready;
    for (int i = N_ST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < N_ST; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // sample saturation and magnitudes
  always_comb begin
    xs = saturate(s_axis_tdata[FIELD_BITS-1:0]);
    ys = saturate(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    mx = magnitude(xs);
    my = magnitude(ys);
  end

  // quadrant correction of the quotient
  always_comb begin
    ang_next = ANG_CALC_W'(quo[QUOT_BITS]);
    if (quad[ST_ANG-1].swap) ang_next = ANG_CALC_W'(ANGLE_QUARTER) - ang_next;
    if (quad[ST_ANG-1].xneg) ang_next = ANG_CALC_W'(ANGLE_HALF) - ang_next;
    if (quad[ST_ANG-1].yneg) ang_next = ANG_CALC_W'(ANGLE_FULL) - ang_next;
    if (ang_next < 0) ang_next = ang_next + ANG_CALC_W'(ANGLE_FULL);
    if (ang_next >= ANG_CALC_W'(ANGLE_FULL)) ang_next = ang_next - ANG_CALC_W'(ANGLE_FULL);
  end

  // sector: angle*SECTORS/3600 by reciprocal multiply, low bits kept
  assign sec_prod = SEC_PROD_W'(ang) * SEC_PROD_W'(SEC_MULT);

  // datapath registers
  always_ff @(posedge clk) begin
    // stage 0: order magnitudes, keep the signs
    if (adv[0]) begin
      big          <= (mx >= my) ? mx : my;
      lesser       <= (mx >= my) ? my : mx;
      quad[0].xneg <= xs[SAT_W-1];
      quad[0].yneg <= ys[SAT_W-1];
      quad[0].swap <= (mx < my);
    end
    // stage 1: squares and cross product
    if (adv[1]) begin
      p_ab    <= PROD_W'(big) * PROD_W'(lesser);
      p_aa    <= PROD_W'(big) * PROD_W'(big);
      p_bb    <= PROD_W'(lesser) * PROD_W'(lesser);
      quad[1] <= quad[0];
    end
    // stage 2: numerator and denominator
    if (adv[2]) begin
      rem[0]  <= NUM_W'(p_ab) * NUM_W'(ATAN_NUM);
      den[0]  <= (DEN_W'(p_aa) << 4) + (DEN_W'(p_aa) << 1)
               + (DEN_W'(p_bb) << 2) + DEN_W'(p_bb) + DEN_W'(1);
      quad[2] <= quad[1];
    end
    // quotient stages: one restoring step per stage, most significant bit first
    for (int j = 0; j < QUOT_BITS; j++) begin
      if (adv[ST_DIV0+j]) begin
        logic [NUM_W-1:0]     trial;
        logic [QUOT_BITS-1:0] qin;
        trial = NUM_W'(den[j]) << (QUOT_BITS - 1 - j);
        qin   = (j == 0) ? '0 : quo[(j == 0) ? 1 : j];
        if (rem[j] >= trial) begin
          rem[j+1] <= rem[j] - trial;
          quo[j+1] <= qin | (QUOT_BITS'(1) << (QUOT_BITS - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          quo[j+1] <= qin;
        end
        den[j+1]          <= den[j];
        quad[ST_DIV0 + j] <= quad[ST_DIV0 + j - 1];
      end
    end
    // angle stage
    if (adv[ST_ANG]) begin
      ang <= ang_next[ANGLE_W-1:0];
    end
    // output register
    if (adv[ST_SEC]) begin
      out_angle  <= ang;
      out_sector <= sec_prod[RECIP_SHIFT +: SECTOR_W];
    end
  end

  assign m_axis_tvalid = vld[ST_SEC];
  assign m_axis_tdata  = {(OUT_DATA_W - ANGLE_W - SECTOR_W)'(0), out_sector, out_angle};

  // input held off only while the whole pipeline is full and stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&vld)))
    else $error("input stalled with room in the pipeline");

  // last quotient step leaves a remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    vld[ST_ANG-1] |-> (rem[QUOT_BITS] < NUM_W'(den[QUOT_BITS])))
    else $error("quotient pipeline remainder out of range");

  // angle delivered within one turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[ANGLE_W-1:0] < ANGLE_W'(ANGLE_FULL)))
    else $error("angle beyond full turn");

endmodule
